// ----- design/lkvc_pkg.sv -----
package lkvc_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Operation codes carried in the opcode field.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Returned on a get miss and for every put.
  localparam logic signed [VALUE_W-1:0] MISS_VALUE = '1;

endpackage

// ----- design/lkvc_req_if.sv -----
interface lkvc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [lkvc_pkg::KEY_W-1:0]    lookup_key;
  logic signed [lkvc_pkg::VALUE_W-1:0]  store_value;

  modport source (output valid, output opcode, output lookup_key, output store_value,
                  input ready);
  modport sink (input valid, input opcode, input lookup_key, input store_value,
                output ready);
endinterface

// ----- design/lkvc_rsp_if.sv -----
interface lkvc_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic signed [lkvc_pkg::VALUE_W-1:0]  read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink (input valid, input found, input read_value, output ready);
endinterface

// ----- design/lkvc_cfg_if.sv -----
interface lkvc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lkvc_pkg::CAP_W-1:0]    capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// ----- design/lkvc_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [ADDR_W-1:0]       raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lru_key_value_cache.sv -----
// Channel  Role    Payload                                  Transaction
// -------  ------  ---------------------------------------  -------------------------
// req      sink    opcode, lookup_key, store_value          one get or put operation
// rsp      source  found, read_value                        one result per operation
// cfg      sink    capacity                                 one capacity register write
//
// Each operation scans all entries once for the key, the least recent and the first free
// entry, then, unless it is a get miss or a put that cannot store, a second pass ages ranks
// and writes the target back. The result is loaded in the done state after the last pass;
// each pass reads the entries one by one through the single read port of the entry RAM.
// Reset is synchronous; it clears the valid bits and occupancy and sets capacity to 16.
// A request is taken while the previous result still waits; its own result then waits.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  lkvc_req_if.sink    req,
  lkvc_rsp_if.source  rsp,
  lkvc_cfg_if.sink    cfg
);

  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW     = IW;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CW     = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
  localparam int KW     = lkvc_pkg::KEY_W;
  localparam int VW     = lkvc_pkg::VALUE_W;
  localparam int WORD_W = KW + VW + RW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state;

  // Operation being served.
  logic                 op_q;
  logic signed [KW-1:0] key_q;
  logic signed [VW-1:0] val_q;

  // Control state.
  logic [ENTRIES-1:0]       valid_q;
  logic [CNT_W-1:0]         occ_q;
  logic [lkvc_pkg::CAP_W-1:0] cap_q;

  // Read sequencing: iss is the address issued this cycle, pend_idx the entry whose
  // data shows up on the RAM output this cycle.
  logic          iss_on;
  logic [IW-1:0] iss;
  logic          rd_pend;
  logic [IW-1:0] pend_idx;

  // Results of the lookup pass.
  logic          hit_q;
  logic [IW-1:0] hit_idx;
  logic [RW-1:0] hit_rank;
  logic [VW-1:0] hit_val;
  logic          vic_any;
  logic [IW-1:0] vic_idx;
  logic [RW-1:0] vic_rank;
  logic          free_any;
  logic [IW-1:0] free_idx;

  // Plan for the update pass.
  logic          age_all;
  logic          wr_kv;
  logic [IW-1:0] tgt_idx;
  logic [RW-1:0] thr_rank;

  // Output register.
  logic                 out_valid;
  logic                 out_found;
  logic signed [VW-1:0] out_value;

  // RAM port signals.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic [KW-1:0] e_key;
  logic [VW-1:0] e_val;
  logic [RW-1:0] e_rank;
  logic          e_valid;
  logic          last_data;
  logic          is_put;
  logic          occ_lt_cap;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] eff_cap;
  logic          out_free;

  lkvc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss),
    .rdata (ram_rdata)
  );

  assign {e_key, e_val, e_rank} = ram_rdata;
  assign e_valid   = valid_q[pend_idx];
  assign last_data = rd_pend && (pend_idx == IW'(ENTRIES - 1));
  assign is_put    = (op_q == lkvc_pkg::OP_PUT);

  // A capacity of zero acts as one; anything above the entry count saturates.
  always_comb begin
    cap_ext = CW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign occ_lt_cap = (CW'(occ_q) < eff_cap);

  // Update pass write-back. The target becomes the most recent entry; other valid
  // entries that were more recent than the target's old rank age by one. A fill ages
  // every valid entry.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = ram_rdata;
    if (state == S_UPDATE && rd_pend) begin
      if (pend_idx == tgt_idx) begin
        ram_we    = 1'b1;
        ram_wdata = {(wr_kv ? KW'(key_q) : e_key), (wr_kv ? VW'(val_q) : e_val), RW'(0)};
      end else if (e_valid && (age_all || e_rank < thr_rank)) begin
        ram_we    = 1'b1;
        ram_wdata = {e_key, e_val, e_rank + RW'(1)};
      end
    end
  end

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.read_value = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid_q   <= '0;
      occ_q     <= '0;
      cap_q     <= lkvc_pkg::CAPACITY_RESET;
      iss_on    <= 1'b0;
      iss       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        cap_q <= cfg.capacity;
      end

      if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      // Read issue runs through all entries once per pass.
      rd_pend  <= iss_on;
      pend_idx <= iss;
      if (iss_on) begin
        if (iss == IW'(ENTRIES - 1)) begin
          iss_on <= 1'b0;
        end else begin
          iss <= iss + IW'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q     <= req.opcode;
            key_q    <= req.lookup_key;
            val_q    <= req.store_value;
            hit_q    <= 1'b0;
            vic_any  <= 1'b0;
            free_any <= 1'b0;
            iss      <= '0;
            iss_on   <= 1'b1;
            state    <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (rd_pend) begin
            if (e_valid && e_key == KW'(key_q) && !hit_q) begin
              hit_q    <= 1'b1;
              hit_idx  <= pend_idx;
              hit_rank <= e_rank;
              hit_val  <= e_val;
            end
            // Strictly greater keeps the lowest index on a tie.
            if (e_valid && (!vic_any || e_rank > vic_rank)) begin
              vic_any  <= 1'b1;
              vic_idx  <= pend_idx;
              vic_rank <= e_rank;
            end
            if (!e_valid && !free_any) begin
              free_any <= 1'b1;
              free_idx <= pend_idx;
            end
          end
          if (last_data) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          age_all <= 1'b0;
          wr_kv   <= is_put;
          state   <= S_UPDATE;
          iss     <= '0;
          iss_on  <= 1'b1;
          if (hit_q) begin
            tgt_idx  <= hit_idx;
            thr_rank <= hit_rank;
          end else if (!is_put) begin
            iss_on <= 1'b0;
            state  <= S_DONE;
          end else if (occ_lt_cap) begin
            if (free_any) begin
              tgt_idx           <= free_idx;
              age_all           <= 1'b1;
              valid_q[free_idx] <= 1'b1;
              occ_q             <= occ_q + CNT_W'(1);
            end else begin
              iss_on <= 1'b0;
              state  <= S_DONE;
            end
          end else if (vic_any) begin
            tgt_idx  <= vic_idx;
            thr_rank <= vic_rank;
          end else begin
            iss_on <= 1'b0;
            state  <= S_DONE;
          end
        end

        S_UPDATE: begin
          if (last_data) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_found <= hit_q;
            out_value <= (!is_put && hit_q) ? $signed(hit_val) : lkvc_pkg::MISS_VALUE;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Occupancy always matches the number of valid entries.
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid_q)) == occ_q)
    else $error("occupancy count out of step with valid bits");

  // The entry RAM is written only during the update pass.
  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_UPDATE))
    else $error("entry RAM written outside the update pass");

  // A recorded hit always points at a valid entry.
  a_hit_is_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && hit_q) |-> valid_q[hit_idx])
    else $error("hit recorded on an invalid entry");

  // A recorded free slot is still free when the plan is made.
  a_free_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && free_any) |-> !valid_q[free_idx])
    else $error("free slot recorded on a valid entry");

  // A result is loaded only at the end of an operation.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result loaded outside the done state");

endmodule

// ----- bench/lru_key_value_cache_test.sv -----
`timescale 1ns / 1ps

module lru_key_value_cache_test;

  localparam int ENTRIES = 16;
  // Cycles with no transaction on any channel before the run is abandoned. The slowest
  // correct operation plus a long sender gap and a long receiver stall stays well below
  // this, so it leaves a wide margin.
  localparam int IDLE_LIMIT = 2000;
  // Idle cycles allowed after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
  localparam int ITEMS_PER_PHASE = 115;

  // The scoreboard keeps its own copy of the cache contents and recency ranks. Every
  // accepted operation is applied to that copy, and the result it implies is queued
  // until the block returns its result transaction.
  class lru_cache_scoreboard;
    typedef struct {
      logic                                found;
      logic signed [lkvc_pkg::VALUE_W-1:0] value;
    } lookup_result_t;

    bit                                  slot_used [ENTRIES];
    logic signed [lkvc_pkg::KEY_W-1:0]   slot_key [ENTRIES];
    logic signed [lkvc_pkg::VALUE_W-1:0] slot_value [ENTRIES];
    int unsigned                         slot_age [ENTRIES];
    int unsigned                         fill_count;
    logic [lkvc_pkg::CAP_W-1:0]          capacity_reg;
    lookup_result_t                      expected_results [$];

    int error_count;
    int get_count;
    int hit_count;
    int put_count;
    int evict_count;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_age[i] = 0;
      end
      fill_count = 0;
      capacity_reg = lkvc_pkg::CAPACITY_RESET;
    endfunction

    function void write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
      capacity_reg = cap;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Make one slot the most recent; every valid slot that was more recent than it ages.
    function void age_to_front(int slot, int unsigned old_age);
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != slot && slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
      end
      slot_age[slot] = 0;
    endfunction

    function void note_request(logic op, logic signed [lkvc_pkg::KEY_W-1:0] key,
                               logic signed [lkvc_pkg::VALUE_W-1:0] val);
      lookup_result_t res;
      int hit_slot;
      int target;
      int limit;
      int unsigned oldest;

      hit_slot = -1;
      res.value = lkvc_pkg::MISS_VALUE;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_slot < 0 && slot_used[i] && slot_key[i] == key) hit_slot = i;
      end
      res.found = (hit_slot >= 0);

      // A capacity of zero behaves as one, and anything above the entry count saturates.
      limit = int'(capacity_reg);
      if (limit < 1) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;

      if (op == lkvc_pkg::OP_GET) begin
        get_count++;
        if (hit_slot >= 0) begin
          hit_count++;
          res.value = slot_value[hit_slot];
          age_to_front(hit_slot, slot_age[hit_slot]);
        end
      end else begin
        put_count++;
        if (hit_slot >= 0) begin
          slot_value[hit_slot] = val;
          age_to_front(hit_slot, slot_age[hit_slot]);
        end else if (fill_count < limit) begin
          target = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (target < 0 && !slot_used[i]) target = i;
          end
          if (target >= 0) begin
            age_to_front(target, 32'hFFFF_FFFF);
            slot_used[target] = 1'b1;
            slot_key[target] = key;
            slot_value[target] = val;
            fill_count++;
          end
        end else begin
          // Replace the least recent slot; on a tie the lowest index wins.
          target = -1;
          oldest = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && (target < 0 || slot_age[i] > oldest)) begin
              target = i;
              oldest = slot_age[i];
            end
          end
          if (target >= 0) begin
            evict_count++;
            age_to_front(target, oldest);
            slot_key[target] = key;
            slot_value[target] = val;
          end
        end
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(logic found, logic signed [lkvc_pkg::VALUE_W-1:0] value);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no operation outstanding: found=%0b read_value=%0d", found, value);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, found);
        error_count++;
      end
      if (value !== want.value) begin
        $error("read_value: expected %0d, got %0d", want.value, value);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();
  lkvc_cfg_if cfg_ch ();

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  lru_cache_scoreboard sb;

  // When set, the request side sends back to back and the response side never stalls.
  bit tx_steady;
  bit rx_steady;
  int stall_left;
  int idle_cycles;
  int capacity_writes;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Result side: every result transaction is checked against the oldest expectation.
  // Ready is dropped for random stretches unless the current phase runs without stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.found, rsp_ch.read_value);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: the run is abandoned if no channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lru_key_value_cache test failed");
        $finish;
      end
    end
  end

  // Sends one operation. Valid is left high after the transaction so that a following
  // operation with no gap keeps it high without a second assignment in the same step.
  task automatic send_op(input logic op, input logic signed [lkvc_pkg::KEY_W-1:0] key,
                         input logic signed [lkvc_pkg::VALUE_W-1:0] val);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.lookup_key <= key;
    req_ch.store_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, key, val);
  endtask

  // Stops sending and waits until every result is back and the block has settled.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The capacity register is only written while the block has nothing in flight.
  task automatic program_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.capacity <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.write_capacity(cap);
    capacity_writes++;
  endtask

  // Random operations over a small pool of keys, so that hits, updates and evictions
  // are frequent, mixed with fully random keys that nearly always miss.
  task automatic run_random_phase(input int items);
    logic signed [lkvc_pkg::KEY_W-1:0]   key_pool [24];
    int                                  pool_n;
    int                                  r;
    logic                                op;
    logic signed [lkvc_pkg::KEY_W-1:0]   key;
    logic signed [lkvc_pkg::VALUE_W-1:0] val;
    pool_n = $urandom_range(6, 24);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    if ($urandom_range(0, 1)) begin
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7FFF_FFFF;
      key_pool[2] = 0;
      key_pool[3] = -1;
    end
    repeat (items) begin
      op = $urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
      r = $urandom_range(0, 99);
      key = (r < 80) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
      r = $urandom_range(0, 99);
      if (r < 5) val = 32'sh7FFF_FFFF;
      else if (r < 10) val = 32'sh8000_0000;
      else if (r < 13) val = -1;
      else val = $urandom;
      send_op(op, key, val);
    end
  endtask

  initial begin
    logic [lkvc_pkg::CAP_W-1:0] phase_caps [7];
    phase_caps = '{5'd31, 5'd16, 5'd5, 5'd0, 5'd1, 5'd12, 5'd16};

    sb = new();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    capacity_writes = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= lkvc_pkg::OP_GET;
    req_ch.lookup_key <= '0;
    req_ch.store_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.capacity <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The cache only fills once after reset, so the small capacities
    // come first, while occupancy is still low enough for them to matter.
    // A capacity of zero acts as one: the second new key evicts the first.
    program_capacity(5'd0);
    send_op(lkvc_pkg::OP_GET, 0, 0);
    send_op(lkvc_pkg::OP_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_op(lkvc_pkg::OP_GET, 32'sh8000_0000, 0);
    send_op(lkvc_pkg::OP_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_op(lkvc_pkg::OP_GET, 32'sh8000_0000, 0);
    send_op(lkvc_pkg::OP_GET, 32'sh7FFF_FFFF, -1);
    // A hit whose stored value looks the same as the miss value.
    program_capacity(5'd1);
    send_op(lkvc_pkg::OP_PUT, 0, -1);
    send_op(lkvc_pkg::OP_GET, 0, 0);
    // Fill up to three, update in place, then evict the least recent key.
    program_capacity(5'd3);
    send_op(lkvc_pkg::OP_PUT, -1, 0);
    send_op(lkvc_pkg::OP_PUT, 5, 100);
    send_op(lkvc_pkg::OP_PUT, -1, 32'sh1234_5678);
    send_op(lkvc_pkg::OP_GET, 0, 0);
    send_op(lkvc_pkg::OP_PUT, 7, 7);
    send_op(lkvc_pkg::OP_GET, 5, 0);
    // Capacity lowered below occupancy: new keys keep replacing old ones.
    program_capacity(5'd2);
    send_op(lkvc_pkg::OP_PUT, 9, 9);
    send_op(lkvc_pkg::OP_GET, -1, 0);
    send_op(lkvc_pkg::OP_GET, 7, 0);
    // A capacity above the entry count saturates, so free slots are used again.
    program_capacity(5'd31);
    send_op(lkvc_pkg::OP_PUT, 11, 32'sh8000_0000);
    send_op(lkvc_pkg::OP_PUT, 12, 32'sh7FFF_FFFF);
    send_op(lkvc_pkg::OP_PUT, 12, 0);
    send_op(lkvc_pkg::OP_GET, 9, 0);
    send_op(lkvc_pkg::OP_GET, 32'sh8000_0000, 0);

    // Random part: several capacity settings, each with its own idling behavior.
    foreach (phase_caps[p]) begin
      program_capacity(phase_caps[p]);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      run_random_phase(ITEMS_PER_PHASE);
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_idle();

    $display("Covered %0d gets (%0d hits) and %0d puts (%0d evictions)",
             sb.get_count, sb.hit_count, sb.put_count, sb.evict_count);
    $display("across %0d capacity register writes.", capacity_writes);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
